FILE: sv/glcm_pkg.sv
`default_nettype none
package glcm_pkg;

  // commands
  localparam logic [1:0] CMD_PIXEL = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  // register indexes
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_WIDTH    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LEVELS   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CHANNEL  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_OPTIONS  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_STEPS    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_STEP_TAB = 3'd6;

  // channel select codes
  localparam logic [2:0] SEL_RED   = 3'd0;
  localparam logic [2:0] SEL_GREEN = 3'd1;
  localparam logic [2:0] SEL_BLUE  = 3'd2;
  localparam logic [2:0] SEL_ALPHA = 3'd3;

  // option bit positions
  localparam int OPT_SYM  = 0;
  localparam int OPT_NORM = 1;
  localparam int OPT_EXCL = 2;

  localparam int CFG_DATA_W = 64;
  localparam int DIM_W      = 9;
  localparam int CHAN_W     = 8;
  localparam int LEVEL_W    = 8;
  localparam int FRAME_W    = 9;   // level plus transparent flag
  localparam int COUNT_W    = 20;
  localparam int CELL_W     = 25;
  localparam int TABLE_STEPS = 4;
  localparam int STEP_W     = 16;
  localparam int COORD_W    = 14;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 20'hFFFFF;
  localparam logic [CELL_W-1:0]  CELL_ONE  = 25'h1000000;

  // quantizer: level = (2*n*(L-1) + D) / (2*D) via reciprocal and one correction
  localparam int NUM_W       = 19;
  localparam int RECIP_W     = 20;
  localparam int RECIP_SHIFT = 28;
  localparam logic [RECIP_W-1:0] RECIP_ONE = 20'd526344;  // floor(2^28 / 510)
  localparam logic [RECIP_W-1:0] RECIP_SUM = 20'd175448;  // floor(2^28 / 1530)
  localparam logic [9:0]  DEN_ONE   = 10'd255;
  localparam logic [9:0]  DEN_SUM   = 10'd765;
  localparam logic [10:0] DEN2_ONE  = 11'd510;
  localparam logic [10:0] DEN2_SUM  = 11'd1530;

  typedef struct packed {
    logic               start;
    logic [COUNT_W-1:0] dividend;
    logic [COUNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [CELL_W-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

FILE: sv/glcm_ifs.sv
`default_nettype none
interface glcm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic [7:0] first_level;
  logic [7:0] second_level;
  modport source (output valid, command, red, green, blue, alpha, first_level,
                  second_level, input ready);
  modport sink (input valid, command, red, green, blue, alpha, first_level,
                second_level, output ready);
endinterface

interface glcm_out_if;
  logic        valid;
  logic        ready;
  logic [24:0] cell_value;
  logic [19:0] total_pairs;
  modport source (output valid, cell_value, total_pairs, input ready);
  modport sink (input valid, cell_value, total_pairs, output ready);
endinterface

interface glcm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: sv/glcm_div.sv
`default_nettype none
module glcm_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire glcm_pkg::div_req_t req,
  output glcm_pkg::div_rsp_t     rsp
);
  localparam int CW = 20;
  localparam int QW = 25;
  localparam int NW = $clog2(QW);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] dsr_r, dsr_nxt;
  logic [QW-1:0] quo_r, quo_nxt;
  logic [CW:0]   rem2;
  logic          ge;

  // one quotient bit per cycle, remainder stays below the divisor
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    quo_nxt  = quo_r;
    rem2     = {rem_r, 1'b0};
    ge       = rem2 >= {1'b0, dsr_r};
    if (req.start) begin
      ge       = req.dividend >= req.divisor;
      rem_nxt  = ge ? req.dividend - req.divisor : req.dividend;
      dsr_nxt  = req.divisor;
      quo_nxt  = {{(QW-1){1'b0}}, ge};
      cnt_nxt  = NW'(QW - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? CW'(rem2 - {1'b0, dsr_r}) : CW'(rem2);
      quo_nxt = {quo_r[QW-2:0], ge};
      cnt_nxt = cnt_r - NW'(1);
      if (cnt_r == NW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;
endmodule
`default_nettype wire

FILE: sv/gray_level_cooccurrence_matrix_core.sv
// channel  | dir | payload                                              | transfer when
// in_ch    | in  | command, red, green, blue, alpha, first/second_level | valid & ready
// out_ch   | out | cell_value, total_pairs                              | valid & ready
// cfg_ch   | in  | index, data                                          | valid & ready
// pixel: quantize and store the level, then per step and direction skip the pair
//   when out of range, else count it and, with symmetric, its mirror in the count memory
// read: cell lookup, with normalize a division by the total (one quotient bit a cycle)
// reset and clear: sweep all MAX_LEVELS*MAX_LEVELS count memory cells to zero, no input
// a waiting result does not block the next item until another read finishes
`default_nettype none
module gray_level_cooccurrence_matrix_core #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_LEVELS = 256,
  parameter int MAX_STEPS  = 4
) (
  input wire logic  clk,
  input wire logic  rst_n,
  glcm_in_if.sink   in_ch,
  glcm_out_if.source out_ch,
  glcm_cfg_if.sink  cfg_ch
);
  localparam int XW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int HW     = $clog2(MAX_HEIGHT + 1);
  localparam int LW     = $clog2(MAX_LEVELS + 1);
  localparam int FDEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int FAW    = (FDEPTH > 1) ? $clog2(FDEPTH) : 1;
  localparam int CDEPTH = MAX_LEVELS * MAX_LEVELS;
  localparam int CAW    = $clog2(CDEPTH);
  localparam int STEP_LIM = (MAX_STEPS < glcm_pkg::TABLE_STEPS) ? MAX_STEPS
                                                                 : glcm_pkg::TABLE_STEPS;
  localparam int CW  = glcm_pkg::COUNT_W;
  localparam int LVW = glcm_pkg::LEVEL_W;
  localparam int KW  = glcm_pkg::COORD_W;
  localparam int PW  = glcm_pkg::NUM_W + glcm_pkg::RECIP_W;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_CLR  = 4'd1;
  localparam logic [3:0] ST_QMUL = 4'd2;
  localparam logic [3:0] ST_QFIX = 4'd3;
  localparam logic [3:0] ST_NADR = 4'd4;
  localparam logic [3:0] ST_NRD  = 4'd5;
  localparam logic [3:0] ST_NUSE = 4'd6;
  localparam logic [3:0] ST_CRD  = 4'd7;
  localparam logic [3:0] ST_CWR  = 4'd8;
  localparam logic [3:0] ST_FIN  = 4'd9;
  localparam logic [3:0] ST_RDM  = 4'd10;
  localparam logic [3:0] ST_RDD  = 4'd11;
  localparam logic [3:0] ST_DIV  = 4'd12;
  localparam logic [3:0] ST_DONE = 4'd13;

  logic [glcm_pkg::FRAME_W-1:0] frame_mem [FDEPTH];
  logic [CW-1:0]                cnt_mem [CDEPTH];

  logic [3:0] state_r, state_nxt;
  logic [8:0] wid_r, wid_nxt, hgt_r, hgt_nxt, lvl_r, lvl_nxt;
  logic [2:0] chsel_r, chsel_nxt, opt_r, opt_nxt, stepn_r, stepn_nxt;
  logic [63:0] stab_r, stab_nxt;
  logic [XW-1:0] col_r, col_nxt, x_r, x_nxt;
  logic [YW-1:0] row_r, row_nxt, y_r, y_nxt;
  logic [CW-1:0] total_r, total_nxt;
  logic [CAW-1:0] clr_addr_r, clr_addr_nxt;
  logic [CAW-1:0] caddr_r, caddr_nxt, maddr_r, maddr_nxt;
  logic [FAW-1:0] cur_r, cur_nxt, nidx_r, nidx_nxt;
  logic [glcm_pkg::NUM_W-1:0] num_r, num_nxt;
  logic sum_r, sum_nxt, az_r, az_nxt;
  logic [LVW-1:0] qest_r, qest_nxt;
  logic [glcm_pkg::FRAME_W-1:0] own_r, own_nxt;
  logic [1:0] step_i_r, step_i_nxt;
  logic dir_r, dir_nxt, mirror_r, mirror_nxt, inrange_r, inrange_nxt;
  logic [glcm_pkg::CELL_W-1:0] res_r, res_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [glcm_pkg::CELL_W-1:0] out_cell_r, out_cell_nxt;
  logic [CW-1:0] out_total_r, out_total_nxt;
  logic [glcm_pkg::FRAME_W-1:0] frm_q_r;
  logic [CW-1:0] cnt_q_r;

  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [LW-1:0] lv_eff;
  logic [LVW-1:0] lvm1;
  logic [2:0] steps_eff;
  logic in_acc, adv, frm_we, cnt_we;
  logic [CAW-1:0] cnt_waddr;
  logic [CW-1:0] cnt_wdata;
  logic [9:0] n_sel;
  logic [9:0] den;
  logic [17:0] nprod;
  logic [XW:0] colw;
  logic [YW:0] roww;
  logic [PW-1:0] rprod;
  logic [glcm_pkg::NUM_W-1:0] qrem;
  logic [10:0] den2;
  logic [LVW-1:0] qlev;
  logic [7:0] dx, dy;
  logic [KW-1:0] xs, ys, dxs, dys, nx, ny;
  logic inb, order_ok;
  logic [FAW-1:0] nidx;
  logic [LVW-1:0] ref_l, nbr_l;
  logic excl;
  glcm_pkg::div_req_t div_req;
  glcm_pkg::div_rsp_t div_rsp;

  glcm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  function automatic logic [LVW-1:0] clamp_lev(input logic [LVW-1:0] v,
                                               input logic [LW-1:0] lv);
    if ({1'b0, v} >= 9'(lv)) begin
      return LVW'(lv - LW'(1));
    end
    return v;
  endfunction

  // effective sizes
  always_comb begin
    if (wid_r == '0) w_eff = WW'(1);
    else if (32'(wid_r) > 32'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(wid_r);
    if (hgt_r == '0) h_eff = HW'(1);
    else if (32'(hgt_r) > 32'(MAX_HEIGHT)) h_eff = HW'(MAX_HEIGHT);
    else h_eff = HW'(hgt_r);
    if (lvl_r == '0) lv_eff = LW'(1);
    else if (lvl_r > 9'(MAX_LEVELS)) lv_eff = LW'(MAX_LEVELS);
    else lv_eff = LW'(lvl_r);
    lvm1 = LVW'(lv_eff - LW'(1));
    steps_eff = (stepn_r > 3'(STEP_LIM)) ? 3'(STEP_LIM) : stepn_r;
  end

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.cell_value  = out_cell_r;
  assign out_ch.total_pairs = out_total_r;

  // datapath terms
  always_comb begin
    unique case (chsel_r)
      glcm_pkg::SEL_RED:   n_sel = {2'b00, in_ch.red};
      glcm_pkg::SEL_GREEN: n_sel = {2'b00, in_ch.green};
      glcm_pkg::SEL_BLUE:  n_sel = {2'b00, in_ch.blue};
      glcm_pkg::SEL_ALPHA: n_sel = {2'b00, in_ch.alpha};
      default: n_sel = 10'({2'b00, in_ch.red}) + 10'({2'b00, in_ch.green})
                       + 10'({2'b00, in_ch.blue});
    endcase
    den = (chsel_r > glcm_pkg::SEL_ALPHA) ? glcm_pkg::DEN_SUM : glcm_pkg::DEN_ONE;
    nprod = 18'(n_sel) * 18'(lvm1);

    // wrap the position when the frame size changed underneath it
    if ({1'b0, col_r} >= (XW+1)'(w_eff)) begin
      colw = '0;
      roww = {1'b0, row_r} + (YW+1)'(1);
    end else begin
      colw = {1'b0, col_r};
      roww = {1'b0, row_r};
    end
    if (roww >= (YW+1)'(h_eff)) roww = '0;

    rprod = PW'(num_r) * PW'(sum_r ? glcm_pkg::RECIP_SUM : glcm_pkg::RECIP_ONE);
    den2  = sum_r ? glcm_pkg::DEN2_SUM : glcm_pkg::DEN2_ONE;
    qrem  = num_r - glcm_pkg::NUM_W'(glcm_pkg::NUM_W'(qest_r) * glcm_pkg::NUM_W'(den2));
    qlev  = qest_r + LVW'(qrem >= glcm_pkg::NUM_W'(den2));

    dx  = stab_r[glcm_pkg::STEP_W*step_i_r +: 8];
    dy  = stab_r[glcm_pkg::STEP_W*step_i_r + 8 +: 8];
    xs  = KW'(x_r);
    ys  = KW'(y_r);
    dxs = {{(KW-8){dx[7]}}, dx};
    dys = {{(KW-8){dy[7]}}, dy};
    nx  = dir_r ? xs - dxs : xs + dxs;
    ny  = dir_r ? ys - dys : ys + dys;
    inb = !nx[KW-1] && !ny[KW-1] && (nx < KW'(w_eff)) && (ny < KW'(h_eff));
    nidx = FAW'(FAW'(ny[KW-2:0]) * FAW'(w_eff) + FAW'(nx[KW-2:0]));
    order_ok = dir_r ? (nidx < cur_r) : (nidx <= cur_r);

    ref_l = clamp_lev(dir_r ? frm_q_r[LVW-1:0] : own_r[LVW-1:0], lv_eff);
    nbr_l = clamp_lev(dir_r ? own_r[LVW-1:0] : frm_q_r[LVW-1:0], lv_eff);
    excl  = opt_r[glcm_pkg::OPT_EXCL] && (own_r[LVW] || frm_q_r[LVW]);
  end

  always_comb begin
    state_nxt = state_r;
    wid_nxt = wid_r; hgt_nxt = hgt_r; lvl_nxt = lvl_r;
    chsel_nxt = chsel_r; opt_nxt = opt_r; stepn_nxt = stepn_r; stab_nxt = stab_r;
    col_nxt = col_r; row_nxt = row_r; x_nxt = x_r; y_nxt = y_r;
    total_nxt = total_r; clr_addr_nxt = clr_addr_r;
    caddr_nxt = caddr_r; maddr_nxt = maddr_r; cur_nxt = cur_r; nidx_nxt = nidx_r;
    num_nxt = num_r; sum_nxt = sum_r; az_nxt = az_r; qest_nxt = qest_r; own_nxt = own_r;
    step_i_nxt = step_i_r; dir_nxt = dir_r; mirror_nxt = mirror_r;
    inrange_nxt = inrange_r; res_nxt = res_r;
    out_valid_nxt = out_valid_r; out_cell_nxt = out_cell_r; out_total_nxt = out_total_r;
    adv = 1'b0; frm_we = 1'b0; cnt_we = 1'b0;
    cnt_waddr = caddr_r; cnt_wdata = '0;
    div_req.start = 1'b0;
    div_req.dividend = cnt_q_r;
    div_req.divisor  = total_r;

    if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        glcm_pkg::REG_WIDTH:    wid_nxt   = cfg_ch.data[8:0];
        glcm_pkg::REG_HEIGHT:   hgt_nxt   = cfg_ch.data[8:0];
        glcm_pkg::REG_LEVELS:   lvl_nxt   = cfg_ch.data[8:0];
        glcm_pkg::REG_CHANNEL:  chsel_nxt = cfg_ch.data[2:0];
        glcm_pkg::REG_OPTIONS:  opt_nxt   = cfg_ch.data[2:0];
        glcm_pkg::REG_STEPS:    stepn_nxt = cfg_ch.data[2:0];
        glcm_pkg::REG_STEP_TAB: stab_nxt  = cfg_ch.data;
        default: ;
      endcase
    end

    if (out_ch.valid && out_ch.ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_ch.command)
            glcm_pkg::CMD_PIXEL: begin
              num_nxt = {nprod, 1'b0} + glcm_pkg::NUM_W'(den);
              sum_nxt = chsel_r > glcm_pkg::SEL_ALPHA;
              az_nxt  = (in_ch.alpha == '0);
              x_nxt   = XW'(colw);
              y_nxt   = YW'(roww);
              state_nxt = ST_QMUL;
            end
            glcm_pkg::CMD_READ: begin
              caddr_nxt = CAW'(CAW'(in_ch.first_level) * CAW'(lv_eff)
                               + CAW'(in_ch.second_level));
              inrange_nxt = ({1'b0, in_ch.first_level} < 9'(lv_eff)) &&
                            ({1'b0, in_ch.second_level} < 9'(lv_eff));
              state_nxt = ST_RDM;
            end
            glcm_pkg::CMD_CLEAR: begin
              total_nxt = '0;
              col_nxt = '0;
              row_nxt = '0;
              clr_addr_nxt = '0;
              state_nxt = ST_CLR;
            end
            default: ;
          endcase
        end
      end
      ST_CLR: begin
        cnt_we = 1'b1;
        cnt_waddr = clr_addr_r;
        if (clr_addr_r == CAW'(CDEPTH - 1)) state_nxt = ST_IDLE;
        else clr_addr_nxt = clr_addr_r + CAW'(1);
      end
      ST_QMUL: begin
        qest_nxt = rprod[glcm_pkg::RECIP_SHIFT +: LVW];
        cur_nxt = FAW'(FAW'(y_r) * FAW'(w_eff) + FAW'(x_r));
        state_nxt = ST_QFIX;
      end
      ST_QFIX: begin
        own_nxt = {az_r, qlev};
        frm_we = 1'b1;
        step_i_nxt = '0;
        dir_nxt = 1'b0;
        state_nxt = (steps_eff == '0) ? ST_FIN : ST_NADR;
      end
      ST_NADR: begin
        nidx_nxt = nidx;
        if (inb && order_ok) state_nxt = ST_NRD;
        else adv = 1'b1;
      end
      ST_NRD: state_nxt = ST_NUSE;
      ST_NUSE: begin
        if (excl) begin
          adv = 1'b1;
        end else begin
          caddr_nxt = CAW'(CAW'(ref_l) * CAW'(lv_eff) + CAW'(nbr_l));
          maddr_nxt = CAW'(CAW'(nbr_l) * CAW'(lv_eff) + CAW'(ref_l));
          mirror_nxt = opt_r[glcm_pkg::OPT_SYM];
          state_nxt = ST_CRD;
        end
      end
      ST_CRD: state_nxt = ST_CWR;
      ST_CWR: begin
        // read-modify-write, the next read of the same cell comes after this write
        cnt_we = 1'b1;
        cnt_wdata = (cnt_q_r == glcm_pkg::COUNT_MAX) ? cnt_q_r : cnt_q_r + CW'(1);
        if (total_r != glcm_pkg::COUNT_MAX) total_nxt = total_r + CW'(1);
        if (mirror_r) begin
          caddr_nxt = maddr_r;
          mirror_nxt = 1'b0;
          state_nxt = ST_CRD;
        end else begin
          adv = 1'b1;
        end
      end
      ST_FIN: begin
        if ((XW+1)'(x_r) + (XW+1)'(1) >= (XW+1)'(w_eff)) begin
          col_nxt = '0;
          if ((YW+1)'(y_r) + (YW+1)'(1) >= (YW+1)'(h_eff)) row_nxt = '0;
          else row_nxt = y_r + YW'(1);
        end else begin
          col_nxt = x_r + XW'(1);
          row_nxt = y_r;
        end
        state_nxt = ST_IDLE;
      end
      ST_RDM: state_nxt = ST_RDD;
      ST_RDD: begin
        div_req.dividend = inrange_r ? cnt_q_r : '0;
        if (opt_r[glcm_pkg::OPT_NORM] && total_r != '0) begin
          div_req.start = 1'b1;
          state_nxt = ST_DIV;
        end else begin
          res_nxt = glcm_pkg::CELL_W'(div_req.dividend);
          state_nxt = ST_DONE;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          res_nxt = div_rsp.quotient;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_cell_nxt = res_r;
          out_total_nxt = total_r;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // move to the next step and direction
    if (adv) begin
      if (!dir_r) begin
        dir_nxt = 1'b1;
        state_nxt = ST_NADR;
      end else if ({1'b0, step_i_r} + 3'd1 < steps_eff) begin
        dir_nxt = 1'b0;
        step_i_nxt = step_i_r + 2'd1;
        state_nxt = ST_NADR;
      end else begin
        state_nxt = ST_FIN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      wid_r <= 9'd256;
      hgt_r <= 9'd256;
      lvl_r <= 9'd256;
      chsel_r <= glcm_pkg::SEL_RED;
      opt_r <= '0;
      stepn_r <= 3'd1;
      stab_r <= 64'd1;
      col_r <= '0;
      row_r <= '0;
      total_r <= '0;
      clr_addr_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wid_r <= wid_nxt;
      hgt_r <= hgt_nxt;
      lvl_r <= lvl_nxt;
      chsel_r <= chsel_nxt;
      opt_r <= opt_nxt;
      stepn_r <= stepn_nxt;
      stab_r <= stab_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
      total_r <= total_nxt;
      clr_addr_r <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    caddr_r <= caddr_nxt;
    maddr_r <= maddr_nxt;
    cur_r <= cur_nxt;
    nidx_r <= nidx_nxt;
    num_r <= num_nxt;
    sum_r <= sum_nxt;
    az_r <= az_nxt;
    qest_r <= qest_nxt;
    own_r <= own_nxt;
    step_i_r <= step_i_nxt;
    dir_r <= dir_nxt;
    mirror_r <= mirror_nxt;
    inrange_r <= inrange_nxt;
    res_r <= res_nxt;
    out_cell_r <= out_cell_nxt;
    out_total_r <= out_total_nxt;
  end

  always_ff @(posedge clk) begin
    if (frm_we) frame_mem[cur_r] <= own_nxt;
    frm_q_r <= frame_mem[nidx_r];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    cnt_q_r <= cnt_mem[caddr_r];
  end
endmodule
`default_nettype wire

FILE: sv/glcm_checker.sv
`default_nettype none
module glcm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [1:0]  in_command,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [24:0] out_cell_value,
  input wire logic [19:0] out_total_pairs
);
  a_reset_no_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cell_value) &&
                                $stable(out_total_pairs))
    else $error("stalled result changed");

  a_cell_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_cell_value <= glcm_pkg::CELL_ONE)
    else $error("cell value above full scale");

  a_busy_after_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command != glcm_pkg::CMD_NONE |=> !in_ready)
    else $error("input ready again in the cycle after an item");

  a_clear_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command == glcm_pkg::CMD_CLEAR |=> ##1 !in_ready)
    else $error("input ready during clearing pass");
endmodule

bind gray_level_cooccurrence_matrix_core glcm_checker u_glcm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_command      (in_ch.command),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_cell_value  (out_ch.cell_value),
  .out_total_pairs (out_ch.total_pairs)
);
`default_nettype wire
